### rtl/pa_perm_pkg.sv
// Shared widths, codes and reset values for the pedal assist permission unit.
package pa_perm_pkg;

	localparam int GRACE_WIDTH_DEF = 24;

	localparam int STEPS_W  = 8;
	localparam int LOAD_W   = 16;
	localparam int TICKS_W  = 24;
	localparam int DELTA_W  = 16;
	localparam int CFG_W    = 24;
	localparam int CFG_IDX_W = 2;
	localparam int LEFT_W   = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_REQUIRED_STEPS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ENGAGE_LOAD    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GRACE_TICKS    = 2'd2;

	localparam logic [STEPS_W-1:0] REQUIRED_STEPS_RST = 8'd2;
	localparam logic [LOAD_W-1:0]  ENGAGE_LOAD_RST    = 16'd0;
	localparam logic [TICKS_W-1:0] GRACE_TICKS_RST    = 24'd20000;

	localparam logic [2:0] STATE_STOPPED  = 3'd0;
	localparam logic [2:0] STATE_STARTING = 3'd1;
	localparam logic [2:0] STATE_FORWARD  = 3'd2;
	localparam logic [2:0] STATE_STOPPING = 3'd3;
	localparam logic [2:0] STATE_REVERSE  = 3'd4;
	localparam logic [2:0] STATE_INVALID  = 3'd5;

	localparam logic [1:0] SESSION_COLD      = 2'd0;
	localparam logic [1:0] SESSION_ACTIVE    = 2'd1;
	localparam logic [1:0] SESSION_SUSPENDED = 2'd2;

endpackage

### rtl/pedal_assist_permission_fsm_unit.sv
// Pedal assist permission state machine: input register, one-pass update, result register.
//
//  channel | direction | handshake            | contents
//  --------+-----------+----------------------+------------------------------------------
//  in      | in        | in_valid / in_ready  | sensor flags, step count, load, tick delta
//  out     | out       | out_valid / out_ready| state, permission, pulses, flags, grace, session
//  cfg     | in        | cfg_we               | cfg_index, cfg_data (no read-back)
//
// One word per cycle while the output is not stalled, via input and result registers.
// The mode, grace counter and resume latch update as the word leaves the input register.
// Reset restores the register defaults and the stopped mode; no clearing pass.
// A stalled output holds its word; the input register keeps taking words while it is empty
// or moving on, so one word waits inside while the output is held.
module pedal_assist_permission_fsm_unit #(
	parameter int GRACE_WIDTH = pa_perm_pkg::GRACE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pa_perm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pa_perm_pkg::CFG_W-1:0]       cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                dir_inhibit,
	input  logic                                inhibit_reverse,
	input  logic                                cut_active,
	input  logic                                level_zero,
	input  logic                                cadence_sensor_ok,
	input  logic                                torque_sensor_ok,
	input  logic                                pedal_fwd,
	input  logic [pa_perm_pkg::STEPS_W-1:0]     step_count,
	input  logic [pa_perm_pkg::LOAD_W-1:0]      load_level,
	input  logic                                crank_timed_out,
	input  logic                                wheel_moving,
	input  logic [pa_perm_pkg::DELTA_W-1:0]     tick_delta,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [2:0]                          state_code,
	output logic                                assist_allow,
	output logic                                engage_pulse,
	output logic                                resume_pulse,
	output logic                                hard_block,
	output logic                                dir_blocked,
	output logic                                in_stopping,
	output logic [pa_perm_pkg::LEFT_W-1:0]      grace_left,
	output logic [1:0]                          session_code
);

	// compare width wide enough for the grace counter, the grace register and the delta
	localparam int CMP_W = (GRACE_WIDTH > pa_perm_pkg::TICKS_W) ? GRACE_WIDTH
		: pa_perm_pkg::TICKS_W;

	typedef enum logic [2:0] {
		MODE_STOPPED  = pa_perm_pkg::STATE_STOPPED,
		MODE_STARTING = pa_perm_pkg::STATE_STARTING,
		MODE_FORWARD  = pa_perm_pkg::STATE_FORWARD,
		MODE_STOPPING = pa_perm_pkg::STATE_STOPPING,
		MODE_REVERSE  = pa_perm_pkg::STATE_REVERSE,
		MODE_INVALID  = pa_perm_pkg::STATE_INVALID
	} mode_t;

	typedef struct packed {
		logic                            dir_inh;
		logic                            inh_rev;
		logic                            cut;
		logic                            off;
		logic                            cad_ok;
		logic                            trq_ok;
		logic                            fwd;
		logic [pa_perm_pkg::STEPS_W-1:0] steps;
		logic [pa_perm_pkg::LOAD_W-1:0]  load;
		logic                            timed_out;
		logic                            rolling;
		logic [pa_perm_pkg::DELTA_W-1:0] delta;
	} tick_t;

	logic [pa_perm_pkg::STEPS_W-1:0] required_steps_q;
	logic [pa_perm_pkg::LOAD_W-1:0]  engage_load_q;
	logic [pa_perm_pkg::TICKS_W-1:0] grace_ticks_q;

	mode_t                  mode_q;
	logic [GRACE_WIDTH-1:0] grace_q;
	logic                   latch_q;

	logic  valid_s1;
	tick_t tick_s1;
	logic  advance;

	mode_t                  mode_d;
	logic [GRACE_WIDTH-1:0] grace_d;
	logic                   latch_d;
	logic                   engaged;
	logic                   terminal;
	logic                   steps_enough;
	logic                   load_enough;
	logic [CMP_W-1:0]       ticks_ext;
	logic [CMP_W-1:0]       grace_max_ext;
	logic [GRACE_WIDTH-1:0] grace_load;
	logic [CMP_W-1:0]       used_ext;
	logic [1:0]             session_d;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			required_steps_q <= pa_perm_pkg::REQUIRED_STEPS_RST;
			engage_load_q    <= pa_perm_pkg::ENGAGE_LOAD_RST;
			grace_ticks_q    <= pa_perm_pkg::GRACE_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pa_perm_pkg::CFG_REQUIRED_STEPS: begin
					required_steps_q <= cfg_data[pa_perm_pkg::STEPS_W-1:0];
				end
				pa_perm_pkg::CFG_ENGAGE_LOAD: begin
					engage_load_q <= cfg_data[pa_perm_pkg::LOAD_W-1:0];
				end
				pa_perm_pkg::CFG_GRACE_TICKS: begin
					grace_ticks_q <= cfg_data[pa_perm_pkg::TICKS_W-1:0];
				end
				default: begin
					// unknown index: drop the write
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			tick_s1 <= '{dir_inh: dir_inhibit, inh_rev: inhibit_reverse,
				cut: cut_active, off: level_zero, cad_ok: cadence_sensor_ok,
				trq_ok: torque_sensor_ok, fwd: pedal_fwd, steps: step_count,
				load: load_level, timed_out: crank_timed_out, rolling: wheel_moving,
				delta: tick_delta};
		end
	end

	assign terminal  = tick_s1.dir_inh || tick_s1.cut || tick_s1.off ||
		!tick_s1.cad_ok || !tick_s1.trq_ok;
	assign steps_enough = tick_s1.steps >= required_steps_q;
	assign load_enough  = (engage_load_q == '0) || (tick_s1.load >= engage_load_q);

	// saturate the grace register at the counter maximum
	assign ticks_ext     = CMP_W'(grace_ticks_q);
	assign grace_max_ext = CMP_W'({GRACE_WIDTH{1'b1}});
	assign grace_load    = (ticks_ext > grace_max_ext) ? GRACE_WIDTH'(grace_max_ext)
		: GRACE_WIDTH'(ticks_ext);

	// a zero delta counts as one tick
	assign used_ext = (tick_s1.delta == '0) ? CMP_W'(1) : CMP_W'(tick_s1.delta);

	always_comb begin
		mode_d  = mode_q;
		grace_d = grace_q;
		latch_d = latch_q;
		engaged = 1'b0;
		if (tick_s1.dir_inh) begin
			mode_d  = tick_s1.inh_rev ? MODE_REVERSE : MODE_INVALID;
			grace_d = '0;
			latch_d = 1'b0;
		end else if (terminal) begin
			mode_d  = MODE_STOPPED;
			grace_d = '0;
			latch_d = 1'b0;
		end else begin
			case (mode_q)
				MODE_REVERSE, MODE_INVALID: begin
					mode_d  = MODE_STOPPED;
					latch_d = 1'b0;
				end
				MODE_STOPPED: begin
					if (tick_s1.fwd) mode_d = MODE_STARTING;
				end
				MODE_STARTING: begin
					if (!tick_s1.fwd) begin
						mode_d = MODE_STOPPED;
					end else if (steps_enough && load_enough) begin
						mode_d  = MODE_FORWARD;
						engaged = 1'b1;
					end
				end
				MODE_FORWARD: begin
					if (!tick_s1.fwd) begin
						mode_d  = MODE_STOPPING;
						grace_d = grace_load;
						latch_d = 1'b1;
					end
				end
				default: begin
					// stopping, and any stray code, counts the grace down, re-engages forward or drops to stopped
					if (tick_s1.timed_out && !tick_s1.rolling) begin
						mode_d  = MODE_STOPPED;
						grace_d = '0;
						latch_d = 1'b0;
					end else if (tick_s1.fwd && load_enough) begin
						mode_d  = MODE_FORWARD;
						engaged = 1'b1;
					end else if (used_ext >= CMP_W'(grace_q)) begin
						mode_d  = MODE_STOPPED;
						grace_d = '0;
						latch_d = 1'b0;
					end else begin
						grace_d = grace_q - GRACE_WIDTH'(used_ext);
					end
				end
			endcase
		end
	end

	always_comb begin
		case (mode_d)
			MODE_FORWARD, MODE_STOPPING: session_d = pa_perm_pkg::SESSION_ACTIVE;
			MODE_REVERSE, MODE_INVALID:  session_d = pa_perm_pkg::SESSION_SUSPENDED;
			default:                     session_d = pa_perm_pkg::SESSION_COLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_STOPPED;
			grace_q   <= '0;
			latch_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (advance) begin
				mode_q  <= mode_d;
				grace_q <= grace_d;
				// an engagement consumes the latch
				latch_q <= latch_d && !engaged;
			end
			if (advance) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			state_code       <= mode_d;
			assist_allow     <= (mode_d == MODE_FORWARD);
			engage_pulse     <= engaged;
			resume_pulse     <= engaged && latch_d;
			hard_block       <= terminal;
			dir_blocked      <= tick_s1.dir_inh;
			in_stopping      <= (mode_d == MODE_STOPPING);
			grace_left       <= pa_perm_pkg::LEFT_W'(CMP_W'(grace_d));
			session_code     <= session_d;
		end
	end

endmodule

### rtl/pa_perm_chk.sv
// Port-level checker for the pedal assist permission unit, with its bind.
module pa_perm_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [2:0]                     state_code,
	input logic                           assist_allow,
	input logic                           engage_pulse,
	input logic                           resume_pulse,
	input logic                           hard_block,
	input logic                           dir_blocked,
	input logic                           in_stopping,
	input logic [pa_perm_pkg::LEFT_W-1:0] grace_left,
	input logic [1:0]                     session_code
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(state_code) && $stable(grace_left))
		else $error("result word changed while stalled");

	a_state_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (assist_allow == (state_code == pa_perm_pkg::STATE_FORWARD)) &&
			(in_stopping == (state_code == pa_perm_pkg::STATE_STOPPING)))
		else $error("permission or stopping flag disagrees with state");

	a_resume: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && resume_pulse |-> engage_pulse && assist_allow)
		else $error("resume pulse without engagement");

	a_cut_stops: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hard_block && !dir_blocked |->
			state_code == pa_perm_pkg::STATE_STOPPED && grace_left == '0 &&
			session_code == pa_perm_pkg::SESSION_COLD)
		else $error("terminal cause did not force stopped");

	a_dir_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dir_blocked |-> hard_block &&
			(state_code == pa_perm_pkg::STATE_REVERSE ||
			state_code == pa_perm_pkg::STATE_INVALID) &&
			session_code == pa_perm_pkg::SESSION_SUSPENDED)
		else $error("direction inhibit did not force a hold");

endmodule

bind pedal_assist_permission_fsm_unit pa_perm_chk u_pa_perm_chk (.*);
